// ----- rtl/core/axis_angle_vector_rotation_macros.svh -----
// assertion macros for the axis-angle rotation core
// no dependencies
`ifndef AXIS_ANGLE_VECTOR_ROTATION_MACROS_SVH
`define AXIS_ANGLE_VECTOR_ROTATION_MACROS_SVH
// implication checked every cycle outside reset
`define AAVR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked with the consequent in the cycle after the antecedent
`define AAVR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/aavr_pkg.sv -----
// package for the axis-angle rotation core: widths, cordic constants
// no dependencies
`timescale 1ns / 1ps
package aavr_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int AXIS_WIDTH      = 16;
  localparam int CORDIC_STEPS    = 16;
  localparam int CW              = 36; // cordic datapath width
  localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;
  localparam logic [31:0] QUARTER = 32'h4000_0000;

  // atan(2^-i) in turn fraction units of the half angle
  function automatic logic signed [CW-1:0] atan_phase(input logic [3:0] i);
    logic signed [CW-1:0] r;
    begin
      unique case (i)
        4'd0:  r = 36'sh020000000;
        4'd1:  r = 36'sh012E4051E;
        4'd2:  r = 36'sh009FB385B;
        4'd3:  r = 36'sh0051111D4;
        4'd4:  r = 36'sh0028B0D43;
        4'd5:  r = 36'sh00145D7E1;
        4'd6:  r = 36'sh000A2F61E;
        4'd7:  r = 36'sh000517C55;
        4'd8:  r = 36'sh00028BE53;
        4'd9:  r = 36'sh000145F2F;
        4'd10: r = 36'sh0000A2F98;
        4'd11: r = 36'sh0000517CC;
        4'd12: r = 36'sh000028BE6;
        4'd13: r = 36'sh0000145F3;
        4'd14: r = 36'sh00000A2FA;
        default: r = 36'sh00000517D;
      endcase
      return r;
    end
  endfunction
endpackage

// ----- rtl/core/aavr_cordic.sv -----
// pipelined rotation-mode cordic: half angle to weights w1, w2 in Q.24
// depends on aavr_pkg
`timescale 1ns / 1ps
module aavr_cordic #(
  parameter int ANGLE_WIDTH = aavr_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ANGLE_WIDTH-1:0] angle,
  output logic signed [35:0]     w1,
  output logic signed [35:0]     w2
);
  import aavr_pkg::*;
  localparam int N = CORDIC_STEPS;

  logic signed [CW-1:0] x_r [0:N];
  logic signed [CW-1:0] y_r [0:N];
  logic signed [CW-1:0] z_r [0:N];
  logic                 up_r [0:N];
  logic signed [CW-1:0] s_r, c_r;
  logic signed [71:0]   sc_r, ss_r;
  logic signed [35:0]   w1_r, w2_r;
  logic [31:0]          phase, half;

  // angle to half-angle residual
  assign phase = 32'(angle) << (32 - ANGLE_WIDTH);
  assign half  = phase >> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= CORDIC_GAIN;
      y_r[0]  <= '0;
      up_r[0] <= (half >= QUARTER);
      z_r[0]  <= (half >= QUARTER) ? CW'(half - QUARTER) : CW'(half);
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        up_r[i+1] <= up_r[i];
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_phase(4'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_phase(4'(i));
        end
      end
    end
  end

  // quadrant fold, products, rounding
  always_ff @(posedge clk) begin
    if (en) begin
      s_r  <= up_r[N] ? x_r[N] : y_r[N];
      c_r  <= up_r[N] ? -y_r[N] : x_r[N];
      sc_r <= 72'(s_r) * 72'(c_r);
      ss_r <= 72'(s_r) * 72'(s_r);
      w1_r <= 36'((sc_r + (72'sd1 <<< 34)) >>> 35);
      w2_r <= 36'((ss_r + (72'sd1 <<< 34)) >>> 35);
    end
  end
  assign w1 = w1_r;
  assign w2 = w2_r;
endmodule

// ----- rtl/core/aavr_cross.sv -----
// two chained cross products u x p and u x (u x p), with a delay line aligning u x p to u x (u x p)
// depends on aavr_pkg
`timescale 1ns / 1ps
module aavr_cross #(
  parameter int COORD_WIDTH = aavr_pkg::COORD_WIDTH_DEF,
  parameter int DW = COORD_WIDTH + 20
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] px, py, pz,
  input  logic signed [15:0]            ux, uy, uz,
  output logic signed [DW-1:0]          c0, c1, c2,
  output logic signed [DW-1:0]          d0, d1, d2
);
  import aavr_pkg::*;
  localparam int PW = DW + 18;

  logic signed [15:0]   ua_r [0:2];
  logic signed [DW-1:0] cp_r [0:2];
  logic signed [PW-1:0] p1_r [0:2];
  logic signed [PW-1:0] p2_r [0:2];
  logic signed [PW-1:0] q1_r [0:2];
  logic signed [PW-1:0] q2_r [0:2];
  logic signed [DW-1:0] c_r  [0:2];
  logic signed [DW-1:0] cd_r [0:2];
  logic signed [DW-1:0] d_r  [0:2];
  logic signed [15:0]   ub_r [0:2];

  // first products, exact
  always_ff @(posedge clk) begin
    if (en) begin
      ua_r[0] <= ux; ua_r[1] <= uy; ua_r[2] <= uz;
      p1_r[0] <= PW'(uy) * PW'(pz); p2_r[0] <= PW'(uz) * PW'(py);
      p1_r[1] <= PW'(uz) * PW'(px); p2_r[1] <= PW'(ux) * PW'(pz);
      p1_r[2] <= PW'(ux) * PW'(py); p2_r[2] <= PW'(uy) * PW'(px);
    end
  end

  // difference, round half up
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        c_r[k]  <= DW'((p1_r[k] - p2_r[k] + PW'(8192)) >>> 14);
        ub_r[k] <= ua_r[k];
      end
    end
  end

  // second products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) cp_r[k] <= c_r[k];
      q1_r[0] <= PW'(ub_r[1]) * PW'(c_r[2]); q2_r[0] <= PW'(ub_r[2]) * PW'(c_r[1]);
      q1_r[1] <= PW'(ub_r[2]) * PW'(c_r[0]); q2_r[1] <= PW'(ub_r[0]) * PW'(c_r[2]);
      q1_r[2] <= PW'(ub_r[0]) * PW'(c_r[1]); q2_r[2] <= PW'(ub_r[1]) * PW'(c_r[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d_r[k]  <= DW'((q1_r[k] - q2_r[k] + PW'(8192)) >>> 14);
        cd_r[k] <= cp_r[k];
      end
    end
  end

  assign c0 = cd_r[0]; assign c1 = cd_r[1]; assign c2 = cd_r[2];
  assign d0 = d_r[0];  assign d1 = d_r[1];  assign d2 = d_r[2];
endmodule

// ----- rtl/core/axis_angle_vector_rotation.sv -----
// axis-angle (rodrigues) rotation of a 3-D point
// channels: in_* request (point Q16.16, axis Q2.14, binary angle) with in_valid/in_stall;
//   out_* result (rotated point, saturated, overflow flag) with out_valid/out_stall
// one request enters per cycle while in_stall is low; one result per request
// pipeline from the accepting edge to out_valid: 16 cordic stages after
//   the input register, then fold, product and rounding of the weights, then
//   weighted products, sum and saturation
// the whole pipeline advances as one when no stall is pending; a stalled
//   result holds in the output register and the pipe freezes, nothing lost
// in_stall follows out_stall of the same cycle when the output holds a result
// reset (rst_n low, synchronous) clears all valid bits; payload is not reset
// the axis is used as given; a non-unit axis may saturate the result
// depends on aavr_pkg, aavr_cordic, aavr_cross
`timescale 1ns / 1ps
module axis_angle_vector_rotation #(
  parameter int COORD_WIDTH = aavr_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = aavr_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_vec_x,
  input  logic signed [COORD_WIDTH-1:0] in_vec_y,
  input  logic signed [COORD_WIDTH-1:0] in_vec_z,
  input  logic signed [aavr_pkg::AXIS_WIDTH-1:0] in_axis_x,
  input  logic signed [aavr_pkg::AXIS_WIDTH-1:0] in_axis_y,
  input  logic signed [aavr_pkg::AXIS_WIDTH-1:0] in_axis_z,
  input  logic [ANGLE_WIDTH-1:0]        in_turn_angle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_out_x,
  output logic signed [COORD_WIDTH-1:0] out_out_y,
  output logic signed [COORD_WIDTH-1:0] out_out_z,
  output logic                          out_overflow
);
  import aavr_pkg::*;
  `include "axis_angle_vector_rotation_macros.svh"

  localparam int LAT  = CORDIC_STEPS + 4; // stages up to weights ready
  localparam int XLAT = 4;                 // cross path stages
  localparam int DW   = COORD_WIDTH + 6;
  localparam int TW   = DW + 40;
  localparam int TOT  = LAT + 3;

  logic en;
  logic [TOT-1:0] vld_r;
  logic signed [COORD_WIDTH-1:0] pd_r [0:LAT-1][0:2];
  logic signed [DW-1:0] c0, c1, c2, d0, d1, d2;
  logic signed [DW-1:0] cq_r [0:LAT-XLAT-1][0:5];
  logic signed [35:0] w1, w2;
  logic signed [TW-1:0] m1_r [0:2];
  logic signed [TW-1:0] m2_r [0:2];
  logic signed [COORD_WIDTH-1:0] pp_r [0:2];
  logic signed [TW-1:0] t_r [0:2];
  logic signed [COORD_WIDTH-1:0] o_r [0:2];
  logic signed [COORD_WIDTH-1:0] o_nxt [0:2];
  logic ovf_r, ovf_nxt;
  logic signed [TW-1:0] hi_lim, lo_lim;

  // pipeline advances when the output slot is free or being taken
  assign en       = !(vld_r[TOT-1] && out_stall);
  assign in_stall = !en;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[TOT-2:0], in_valid};
  end

  aavr_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic (
    .clk(clk), .en(en), .angle(in_turn_angle), .w1(w1), .w2(w2)
  );

  aavr_cross #(.COORD_WIDTH(COORD_WIDTH), .DW(DW)) u_cross (
    .clk(clk), .en(en), .px(in_vec_x), .py(in_vec_y), .pz(in_vec_z),
    .ux(in_axis_x), .uy(in_axis_y), .uz(in_axis_z),
    .c0(c0), .c1(c1), .c2(c2), .d0(d0), .d1(d1), .d2(d2)
  );

  // align point and cross terms with the weights
  always_ff @(posedge clk) begin
    if (en) begin
      pd_r[0][0] <= in_vec_x; pd_r[0][1] <= in_vec_y; pd_r[0][2] <= in_vec_z;
      for (int s = 1; s < LAT; s++) pd_r[s] <= pd_r[s-1];
      cq_r[0][0] <= c0; cq_r[0][1] <= c1; cq_r[0][2] <= c2;
      cq_r[0][3] <= d0; cq_r[0][4] <= d1; cq_r[0][5] <= d2;
      for (int s = 1; s < LAT - XLAT; s++) cq_r[s] <= cq_r[s-1];
    end
  end

  assign hi_lim = TW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  assign lo_lim = -hi_lim - TW'(1);

  // weighted terms: exact product with round-half-up of the low 24 bits
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        m1_r[k] <= (TW'(cq_r[LAT-XLAT-1][k]) * TW'(w1) + TW'(8388608)) >>> 24;
        m2_r[k] <= (TW'(cq_r[LAT-XLAT-1][k+3]) * TW'(w2) + TW'(8388608)) >>> 24;
        pp_r[k] <= pd_r[LAT-1][k];
      end
    end
  end

  // sum of point and weighted terms
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) t_r[k] <= TW'(pp_r[k]) + m1_r[k] + m2_r[k];
    end
  end

  // saturate
  always_comb begin
    ovf_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (t_r[k] > hi_lim) begin
        o_nxt[k] = {1'b0, {(COORD_WIDTH-1){1'b1}}}; ovf_nxt = 1'b1;
      end else if (t_r[k] < lo_lim) begin
        o_nxt[k] = {1'b1, {(COORD_WIDTH-1){1'b0}}}; ovf_nxt = 1'b1;
      end else begin
        o_nxt[k] = COORD_WIDTH'(t_r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_r   <= o_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign out_valid    = vld_r[TOT-1];
  assign out_out_x    = o_r[0];
  assign out_out_y    = o_r[1];
  assign out_out_z    = o_r[2];
  assign out_overflow = ovf_r;

  `AAVR_ASSERT_IMPL(a_stall_follows, out_valid && out_stall, in_stall)
  `AAVR_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid)
  `AAVR_ASSERT_NEXT(a_hold_data, out_valid && out_stall, $stable(out_out_x) && $stable(out_overflow))
endmodule

// ----- sim/aavr_rotation_checker.sv -----
// checker for the axis-angle rotation core: predicts each rotated point
// and compares it with the result channel; depends on aavr_pkg
`timescale 1ns / 1ps
module aavr_rotation_checker #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_vec_x,
  input  logic signed [COORD_WIDTH-1:0] in_vec_y,
  input  logic signed [COORD_WIDTH-1:0] in_vec_z,
  input  logic signed [15:0]            in_axis_x,
  input  logic signed [15:0]            in_axis_y,
  input  logic signed [15:0]            in_axis_z,
  input  logic [ANGLE_WIDTH-1:0]        in_turn_angle,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [COORD_WIDTH-1:0] out_out_x,
  input  logic signed [COORD_WIDTH-1:0] out_out_y,
  input  logic signed [COORD_WIDTH-1:0] out_out_z,
  input  logic                          out_overflow,
  output int                            fail_count,
  output int                            pending_count
);
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic                          ovf;
  } rotated_point_t;

  rotated_point_t rotated_q[$];

  // atan(2^-i) in half-angle turn units
  localparam longint ATAN_TURNS [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

  // exact rounded (a1*v1 - a2*v2) / 2^14
  function automatic longint axis_cross(longint a1, longint v1, longint a2, longint v2);
    longint h1, h2, l1, l2;
    h1 = v1 >>> 16;
    h2 = v2 >>> 16;
    l1 = v1 - h1 * 65536;
    l2 = v2 - h2 * 65536;
    return (a1 * h1 - a2 * h2) * 4 + ((a1 * l1 - a2 * l2 + 8192) >>> 14);
  endfunction

  // v * w / 2^24, w in Q.24
  function automatic longint scale_q24(longint v, longint w);
    longint h, l;
    h = v >>> 24;
    l = v - h * 16777216;
    return h * w + ((l * w + 8388608) >>> 24);
  endfunction

  function automatic rotated_point_t rotate_point(longint px, longint py, longint pz,
                                                  longint ux, longint uy, longint uz,
                                                  logic [ANGLE_WIDTH-1:0] ang);
    longint p[3], c[3], d[3];
    longint cx, cy, cz, dx, dy, s, co, w1, w2, hi, lo, r;
    logic [31:0] phase, half;
    logic upper;
    rotated_point_t res;
    phase = 32'(ang) << (32 - ANGLE_WIDTH);
    half = phase >> 1;
    upper = half >= aavr_pkg::QUARTER;
    cz = upper ? longint'(half - aavr_pkg::QUARTER) : longint'(half);
    cx = 652032874;
    cy = 0;
    // rotation-mode cordic on the half angle
    for (int i = 0; i < 16; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx -= dx; cy += dy; cz -= ATAN_TURNS[i];
      end else begin
        cx += dx; cy -= dy; cz += ATAN_TURNS[i];
      end
    end
    s = upper ? cx : cy;
    co = upper ? -cy : cx;
    w1 = (s * co + (64'sd1 << 34)) >>> 35;
    w2 = (s * s + (64'sd1 << 34)) >>> 35;
    p[0] = px; p[1] = py; p[2] = pz;
    c[0] = axis_cross(uy, p[2], uz, p[1]);
    c[1] = axis_cross(uz, p[0], ux, p[2]);
    c[2] = axis_cross(ux, p[1], uy, p[0]);
    d[0] = axis_cross(uy, c[2], uz, c[1]);
    d[1] = axis_cross(uz, c[0], ux, c[2]);
    d[2] = axis_cross(ux, c[1], uy, c[0]);
    hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    lo = -hi - 1;
    res.ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      r = p[i] + scale_q24(c[i], w1) + scale_q24(d[i], w2);
      if (r > hi) begin
        r = hi; res.ovf = 1'b1;
      end
      if (r < lo) begin
        r = lo; res.ovf = 1'b1;
      end
      if (i == 0) res.x = r[COORD_WIDTH-1:0];
      else if (i == 1) res.y = r[COORD_WIDTH-1:0];
      else res.z = r[COORD_WIDTH-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  // predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    rotated_point_t want;
    if (rst_n && in_valid && !in_stall)
      rotated_q.push_back(rotate_point(in_vec_x, in_vec_y, in_vec_z,
                                       in_axis_x, in_axis_y, in_axis_z, in_turn_angle));
    if (rst_n && out_valid && !out_stall) begin
      if (rotated_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = rotated_q.pop_front();
        if (out_out_x !== want.x) report_mismatch("out_x", out_out_x, want.x);
        if (out_out_y !== want.y) report_mismatch("out_y", out_out_y, want.y);
        if (out_out_z !== want.z) report_mismatch("out_z", out_out_z, want.z);
        if (out_overflow !== want.ovf) report_mismatch("overflow", out_overflow, want.ovf);
      end
    end
    pending_count = rotated_q.size();
  end
endmodule

// ----- sim/tb_axis_angle_vector_rotation.sv -----
// testbench top for the axis-angle rotation core: drives requests, stalls results
// depends on aavr_pkg, axis_angle_vector_rotation, aavr_rotation_checker
`timescale 1ns / 1ps
module tb_axis_angle_vector_rotation;
  localparam int CW = aavr_pkg::COORD_WIDTH_DEF;
  localparam int AW = aavr_pkg::ANGLE_WIDTH_DEF;
  localparam int RANDOM_REQUESTS = 1900;
  localparam int IDLE_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic signed [15:0] in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  logic [AW-1:0] in_turn_angle = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [CW-1:0] out_out_x, out_out_y, out_out_z;
  logic out_overflow;
  int fail_count, pending_count;
  int idle_cycles = 0;
  bit quiet_out = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  axis_angle_vector_rotation #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) u_top (.*);

  aavr_rotation_checker #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) u_checker (.*);

  // one request: drive, hold until accepted, then a random gap unless no_gap is set
  task automatic send_rotation(logic [CW-1:0] vx, logic [CW-1:0] vy, logic [CW-1:0] vz,
                               logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                               logic [AW-1:0] ang, bit no_gap);
    int gap;
    in_valid <= 1'b1;
    in_vec_x <= vx; in_vec_y <= vy; in_vec_z <= vz;
    in_axis_x <= ax; in_axis_y <= ay; in_axis_z <= az;
    in_turn_angle <= ang;
    do @(posedge clk); while (in_stall);
    gap = no_gap ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] unit_axis_comp(int sel);
    case (sel)
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd9459;   // about 1/sqrt(3)
      3: return -16'sd9459;
      default: return 16'sd0;
    endcase
  endfunction

  // result side stalls: per result a random wait, or none in quiet stretches
  initial begin
    int w;
    @(posedge clk iff rst_n);
    forever begin
      w = quiet_out ? 0 : $urandom_range(0, 8);
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_axis_angle_vector_rotation: FAIL");
      $finish;
    end
  end

  initial begin
    logic [15:0] ax, ay, az;
    logic [CW-1:0] vx, vy, vz;
    logic [AW-1:0] ang;
    int kind, waited;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, quadrant boundaries, non-unit axes, saturation
    send_rotation(32'h0001_0000, '0, '0, '0, '0, 16'sd16384, 16'h4000, 1'b0);
    send_rotation(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  16'sd16384, '0, '0, 16'h8000, 1'b0);
    send_rotation(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 1'b0);
    send_rotation(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b1);
    send_rotation(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  16'h7FFF, 16'h8000, 16'h7FFF, 16'h8001, 1'b1);
    send_rotation(32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F,
                  16'sd9459, 16'sd9459, 16'sd9459, 16'h7FFF, 1'b0);
    send_rotation(32'hFFFF_FFFF, 32'd1, 32'h8000_0001, '0, 16'sd16384, '0, 16'h0001, 1'b0);
    send_rotation(32'h4000_0000, 32'hC000_0000, '0, '0, '0, -16'sd16384, 16'hC000, 1'b0);
    send_rotation('0, '0, '0, 16'h7FFF, 16'h8000, '0, 16'h2000, 1'b0);
    send_rotation(32'h0003_0000, 32'h0004_0000, 32'h0005_0000,
                  16'h5555, 16'hAAAA, 16'h1234, 16'hE000, 1'b0);

    // random: mostly axes from fixed component values with random points, the rest raw noise
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      kind = $urandom_range(0, 9);
      quiet_out = (n / 200) % 4 == 3;
      ang = AW'($urandom);
      if (kind < 6) begin
        ax = unit_axis_comp($urandom_range(0, 4));
        ay = unit_axis_comp($urandom_range(0, 4));
        az = unit_axis_comp($urandom_range(0, 4));
        vx = CW'($signed($urandom) >>> $urandom_range(0, 16));
        vy = CW'($signed($urandom) >>> $urandom_range(0, 16));
        vz = CW'($signed($urandom) >>> $urandom_range(0, 16));
      end else begin
        ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
        vx = CW'($urandom); vy = CW'($urandom); vz = CW'($urandom);
      end
      send_rotation(vx, vy, vz, ax, ay, az, ang, (n / 150) % 4 == 2);
    end
    in_valid <= 1'b0;

    // drain, then a short settle
    waited = 0;
    while (pending_count != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_axis_angle_vector_rotation: PASS");
    end else begin
      $display("tb_axis_angle_vector_rotation: FAIL");
    end
    $finish;
  end
endmodule
